>>> hdl/assert_macros.svh
// Assertion macros shared by the segment intersection test design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/segint_pkg.sv
// Shared types, widths, codes and helper functions of the segment intersection test.
package segint_pkg;

   // Coordinate width and the widths that follow from it.
   localparam int COORD_BITS    = 16;
   localparam int DIFF_BITS     = COORD_BITS + 1;
   localparam int PROD_BITS     = 2 * DIFF_BITS;
   localparam int NUM_COORDS    = 8;
   localparam int REQ_DATA_BITS = ((NUM_COORDS * COORD_BITS + 7) / 8) * 8;
   localparam int VERDICT_BITS  = 2;
   localparam int RSP_DATA_BITS = 8;

   // Verdict codes.
   localparam logic [VERDICT_BITS-1:0] VERDICT_CROSS    = 2'd0;
   localparam logic [VERDICT_BITS-1:0] VERDICT_PARALLEL = 2'd1;
   localparam logic [VERDICT_BITS-1:0] VERDICT_SKEW     = 2'd2;

   // Orientation of a point against a directed line.
   typedef enum logic [1:0] {
      ORI_LINE = 2'd0,
      ORI_CW   = 2'd1,
      ORI_CCW  = 2'd2
   } ori_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   // Operands of one product comparison: p*q against r*s.
   typedef struct packed {
      diff_type p;
      diff_type q;
      diff_type r;
      diff_type s;
   } cmp_ops_type;

   // One product pair: lhs = p*q, rhs = r*s.
   typedef struct packed {
      prod_type lhs;
      prod_type rhs;
   } prod_pair_type;

   // Stage one result: operands of the four turns and the slope test, plus flags.
   typedef struct packed {
      cmp_ops_type t1;
      cmp_ops_type t2;
      cmp_ops_type t3;
      cmp_ops_type t4;
      cmp_ops_type slope;
      logic [3:0]  in_box;
      logic        a_zero;
      logic        b_zero;
   } diff_stage_type;

   // Stage two result: the products.
   typedef struct packed {
      prod_pair_type t1;
      prod_pair_type t2;
      prod_pair_type t3;
      prod_pair_type t4;
      prod_pair_type slope;
      logic [3:0]    in_box;
      logic          a_zero;
      logic          b_zero;
   } prod_stage_type;

   // Stage three result: orientations and the slope test.
   typedef struct packed {
      ori_type    t1;
      ori_type    t2;
      ori_type    t3;
      ori_type    t4;
      logic       slope_eq;
      logic [3:0] in_box;
      logic       a_zero;
      logic       b_zero;
   } ori_stage_type;

   // Difference b - a, one bit wider than a coordinate so it never overflows.
   function automatic diff_type diff_of(coord_type a, coord_type b);
      diff_type ea;
      diff_type eb;
      ea = DIFF_BITS'(a);
      eb = DIFF_BITS'(b);
      return eb - ea;
   endfunction

   // Exact signed product of two differences.
   function automatic prod_type mul_of(diff_type a, diff_type b);
      prod_type ea;
      prod_type eb;
      ea = PROD_BITS'(a);
      eb = PROD_BITS'(b);
      return ea * eb;
   endfunction

   // True when m lies in the bounding box of the segment from e0 to e1.
   function automatic logic in_box_of(point_type e0, point_type m, point_type e1);
      logic ok_x;
      logic ok_y;
      ok_x = (m.x <= e0.x || m.x <= e1.x) && (m.x >= e0.x || m.x >= e1.x);
      ok_y = (m.y <= e0.y || m.y <= e1.y) && (m.y >= e0.y || m.y >= e1.y);
      return ok_x && ok_y;
   endfunction

   // Orientation from a product pair.
   function automatic ori_type ori_of(prod_pair_type pp);
      ori_type o;
      if (pp.lhs == pp.rhs) begin
         o = ORI_LINE;
      end else if (pp.lhs > pp.rhs) begin
         o = ORI_CW;
      end else begin
         o = ORI_CCW;
      end
      return o;
   endfunction

endpackage

>>> hdl/segment_intersection_test.sv
// Top level of the segment intersection test: four-stage pipeline and stream ports.
// Classifies a pair of plane segments A and B as touching or crossing, parallel
// without contact, or non-parallel without contact, with exact integer arithmetic.
// One pair is taken per clock cycle while the result side does not stall. The verdict
// is computed through the difference, product and compare registers and appears on
// the output register, which drives the result transfer.
// The rate is set by the pipeline: differences, ten 17-by-17 multipliers, product
// compares and the final classification each occupy one register stage, so a new
// pair enters every cycle while earlier ones move on; a stall on the result side
// holds each occupied stage and fills empty ones until the request side stops.
`include "assert_macros.svh"

module segment_intersection_test (
   input  logic                                  clock,
   input  logic                                  reset,
   // Fields from bit 0 up: a_start_x, a_start_y, a_end_x, a_end_y,
   // b_start_x, b_start_y, b_end_x, b_end_y, each 16 bits signed.
   input  logic [segint_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // Fields from bit 0 up: verdict (2 bits), then zero fill.
   output logic [segint_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready
);

   logic                                valid1;
   logic                                valid2;
   logic                                valid3;
   logic                                valid4;
   logic                                ready1;
   logic                                ready2;
   logic                                ready3;
   logic                                ready4;
   segint_pkg::diff_stage_type          data1;
   segint_pkg::prod_stage_type          data2;
   segint_pkg::ori_stage_type           data3;
   logic [segint_pkg::VERDICT_BITS-1:0] verdict;

   // A stage may load when it is empty or its content moves on this cycle.
   assign ready4     = !valid4 || rsp_tready;
   assign ready3     = !valid3 || ready4;
   assign ready2     = !valid2 || ready3;
   assign ready1     = !valid1 || ready2;
   assign req_tready = ready1;

   segint_diff u_diff (
      .clock    (clock),
      .reset    (reset),
      .load     (ready1),
      .in_valid (req_tvalid),
      .in_data  (req_tdata),
      .valid_ff (valid1),
      .data_ff  (data1)
   );

   segint_mult u_mult (
      .clock    (clock),
      .reset    (reset),
      .load     (ready2),
      .in_valid (valid1),
      .in_data  (data1),
      .valid_ff (valid2),
      .data_ff  (data2)
   );

   segint_cmp u_cmp (
      .clock    (clock),
      .reset    (reset),
      .load     (ready3),
      .in_valid (valid2),
      .in_data  (data2),
      .valid_ff (valid3),
      .data_ff  (data3)
   );

   segint_class u_class (
      .clock      (clock),
      .reset      (reset),
      .load       (ready4),
      .in_valid   (valid3),
      .in_data    (data3),
      .valid_ff   (valid4),
      .verdict_ff (verdict)
   );

   // Result transfer: verdict in the low bits, zero fill above.
   assign rsp_tvalid = valid4;
   assign rsp_tdata  = {{(segint_pkg::RSP_DATA_BITS - segint_pkg::VERDICT_BITS){1'b0}}, verdict};

   // An accepted request always lands in the first stage.
   `ASSERT_NEXT(a_req_lands, clock, reset, req_tvalid && req_tready, valid1, "request dropped")

   // A blocked stage three keeps its item.
   `ASSERT_NEXT(a_stage3_holds, clock, reset, valid3 && !ready4, valid3, "stage three dropped")

   // The unused verdict code, both bits set, never reaches the output.
   `ASSERT_NOW(a_verdict_code, clock, reset, rsp_tvalid, !(&verdict), "unused verdict code")

endmodule

>>> hdl/segint_diff.sv
// Stage one: coordinate differences, bounding-box tests and zero-length flags.
module segint_diff (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    load,
   input  logic                                    in_valid,
   input  logic [segint_pkg::REQ_DATA_BITS-1:0]    in_data,
   output logic                                    valid_ff,
   output segint_pkg::diff_stage_type              data_ff
);

   segint_pkg::point_type      a0;
   segint_pkg::point_type      a1;
   segint_pkg::point_type      b0;
   segint_pkg::point_type      b1;
   segint_pkg::diff_stage_type data_in;
   segint_pkg::diff_type       dxa;
   segint_pkg::diff_type       dya;
   segint_pkg::diff_type       dxb;
   segint_pkg::diff_type       dyb;

   // Unpack the points from the transfer payload, first field lowest.
   always_comb begin
      a0.x = in_data[0*segint_pkg::COORD_BITS +: segint_pkg::COORD_BITS];
      a0.y = in_data[1*segint_pkg::COORD_BITS +: segint_pkg::COORD_BITS];
      a1.x = in_data[2*segint_pkg::COORD_BITS +: segint_pkg::COORD_BITS];
      a1.y = in_data[3*segint_pkg::COORD_BITS +: segint_pkg::COORD_BITS];
      b0.x = in_data[4*segint_pkg::COORD_BITS +: segint_pkg::COORD_BITS];
      b0.y = in_data[5*segint_pkg::COORD_BITS +: segint_pkg::COORD_BITS];
      b1.x = in_data[6*segint_pkg::COORD_BITS +: segint_pkg::COORD_BITS];
      b1.y = in_data[7*segint_pkg::COORD_BITS +: segint_pkg::COORD_BITS];
   end

   // Operands of each turn: (b.y-a.y)*(c.x-b.x) against (b.x-a.x)*(c.y-b.y).
   always_comb begin
      dxa = segint_pkg::diff_of(a0.x, a1.x);
      dya = segint_pkg::diff_of(a0.y, a1.y);
      dxb = segint_pkg::diff_of(b0.x, b1.x);
      dyb = segint_pkg::diff_of(b0.y, b1.y);

      data_in.t1.p = dya;
      data_in.t1.q = segint_pkg::diff_of(a1.x, b0.x);
      data_in.t1.r = dxa;
      data_in.t1.s = segint_pkg::diff_of(a1.y, b0.y);

      data_in.t2.p = dya;
      data_in.t2.q = segint_pkg::diff_of(a1.x, b1.x);
      data_in.t2.r = dxa;
      data_in.t2.s = segint_pkg::diff_of(a1.y, b1.y);

      data_in.t3.p = dyb;
      data_in.t3.q = segint_pkg::diff_of(b1.x, a0.x);
      data_in.t3.r = dxb;
      data_in.t3.s = segint_pkg::diff_of(b1.y, a0.y);

      data_in.t4.p = dyb;
      data_in.t4.q = segint_pkg::diff_of(b1.x, a1.x);
      data_in.t4.r = dxb;
      data_in.t4.s = segint_pkg::diff_of(b1.y, a1.y);

      // Equal slopes when dya*dxb equals dyb*dxa.
      data_in.slope.p = dya;
      data_in.slope.q = dxb;
      data_in.slope.r = dyb;
      data_in.slope.s = dxa;

      data_in.in_box[0] = segint_pkg::in_box_of(a0, b0, a1);
      data_in.in_box[1] = segint_pkg::in_box_of(a0, b1, a1);
      data_in.in_box[2] = segint_pkg::in_box_of(b0, a0, b1);
      data_in.in_box[3] = segint_pkg::in_box_of(b0, a1, b1);

      data_in.a_zero = (dxa == '0) && (dya == '0);
      data_in.b_zero = (dxb == '0) && (dyb == '0);
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> hdl/segint_mult.sv
// Stage two: the ten signed products of the turn and slope tests.
module segint_mult (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic                        in_valid,
   input  segint_pkg::diff_stage_type  in_data,
   output logic                        valid_ff,
   output segint_pkg::prod_stage_type  data_ff
);

   segint_pkg::prod_stage_type data_in;

   // One multiplier per product, each registered below.
   always_comb begin
      data_in.t1.lhs    = segint_pkg::mul_of(in_data.t1.p, in_data.t1.q);
      data_in.t1.rhs    = segint_pkg::mul_of(in_data.t1.r, in_data.t1.s);
      data_in.t2.lhs    = segint_pkg::mul_of(in_data.t2.p, in_data.t2.q);
      data_in.t2.rhs    = segint_pkg::mul_of(in_data.t2.r, in_data.t2.s);
      data_in.t3.lhs    = segint_pkg::mul_of(in_data.t3.p, in_data.t3.q);
      data_in.t3.rhs    = segint_pkg::mul_of(in_data.t3.r, in_data.t3.s);
      data_in.t4.lhs    = segint_pkg::mul_of(in_data.t4.p, in_data.t4.q);
      data_in.t4.rhs    = segint_pkg::mul_of(in_data.t4.r, in_data.t4.s);
      data_in.slope.lhs = segint_pkg::mul_of(in_data.slope.p, in_data.slope.q);
      data_in.slope.rhs = segint_pkg::mul_of(in_data.slope.r, in_data.slope.s);
      data_in.in_box    = in_data.in_box;
      data_in.a_zero    = in_data.a_zero;
      data_in.b_zero    = in_data.b_zero;
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> hdl/segint_cmp.sv
// Stage three: product comparisons that give the four orientations and slope equality.
module segint_cmp (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic                        in_valid,
   input  segint_pkg::prod_stage_type  in_data,
   output logic                        valid_ff,
   output segint_pkg::ori_stage_type   data_ff
);

   segint_pkg::ori_stage_type data_in;

   // Signed compares of each product pair.
   always_comb begin
      data_in.t1       = segint_pkg::ori_of(in_data.t1);
      data_in.t2       = segint_pkg::ori_of(in_data.t2);
      data_in.t3       = segint_pkg::ori_of(in_data.t3);
      data_in.t4       = segint_pkg::ori_of(in_data.t4);
      data_in.slope_eq = (in_data.slope.lhs == in_data.slope.rhs);
      data_in.in_box   = in_data.in_box;
      data_in.a_zero   = in_data.a_zero;
      data_in.b_zero   = in_data.b_zero;
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> hdl/segint_class.sv
// Stage four: the final classification and the output register.
module segint_class (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  logic                                  in_valid,
   input  segint_pkg::ori_stage_type             in_data,
   output logic                                  valid_ff,
   output logic [segint_pkg::VERDICT_BITS-1:0]   verdict_ff
);

   logic [segint_pkg::VERDICT_BITS-1:0] verdict_in;
   logic                                crossing;
   logic                                touching;
   logic                                all_line;

   // Contact first, then the collinear, zero-length and slope tests.
   always_comb begin
      crossing = (in_data.t1 != in_data.t2) && (in_data.t3 != in_data.t4);
      touching = (in_data.t1 == segint_pkg::ORI_LINE && in_data.in_box[0]) ||
                 (in_data.t2 == segint_pkg::ORI_LINE && in_data.in_box[1]) ||
                 (in_data.t3 == segint_pkg::ORI_LINE && in_data.in_box[2]) ||
                 (in_data.t4 == segint_pkg::ORI_LINE && in_data.in_box[3]);
      all_line = (in_data.t1 == segint_pkg::ORI_LINE) &&
                 (in_data.t2 == segint_pkg::ORI_LINE) &&
                 (in_data.t3 == segint_pkg::ORI_LINE) &&
                 (in_data.t4 == segint_pkg::ORI_LINE);
      if (crossing || touching) begin
         verdict_in = segint_pkg::VERDICT_CROSS;
      end else if (all_line) begin
         verdict_in = segint_pkg::VERDICT_PARALLEL;
      end else if (in_data.a_zero || in_data.b_zero) begin
         // A segment of zero length has no slope.
         verdict_in = segint_pkg::VERDICT_SKEW;
      end else if (in_data.slope_eq) begin
         verdict_in = segint_pkg::VERDICT_PARALLEL;
      end else begin
         verdict_in = segint_pkg::VERDICT_SKEW;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         verdict_ff <= verdict_in;
      end
   end

endmodule

>>> sim/segment_intersection_test_tb.sv
// Self-checking testbench for the segment intersection test with a verdict scoreboard.
module segment_intersection_test_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import segint_pkg::*;

   // One request: the four end points of segments A and B.
   typedef struct {
      point_type a0;
      point_type a1;
      point_type b0;
      point_type b1;
   } seg_pair_type;

   // Predicts the verdict of every accepted pair and checks results in order.
   class verdict_scoreboard;
      logic [RSP_DATA_BITS-1:0] pending_verdicts[$];
      int mismatches;

      // Side of the directed line p->q on which r lies, from an exact cross product.
      function ori_type turn_of(point_type p, point_type q, point_type r);
         diff_type dy_pq;
         diff_type dx_qr;
         diff_type dx_pq;
         diff_type dy_qr;
         prod_type lhs;
         prod_type rhs;
         dy_pq = diff_type'(q.y) - diff_type'(p.y);
         dx_qr = diff_type'(r.x) - diff_type'(q.x);
         dx_pq = diff_type'(q.x) - diff_type'(p.x);
         dy_qr = diff_type'(r.y) - diff_type'(q.y);
         lhs = prod_type'(dy_pq) * prod_type'(dx_qr);
         rhs = prod_type'(dx_pq) * prod_type'(dy_qr);
         if (lhs == rhs) return ORI_LINE;
         if (lhs > rhs) return ORI_CW;
         return ORI_CCW;
      endfunction

      // True when m lies in the bounding box spanned by e0 and e1.
      function bit within_box(point_type e0, point_type m, point_type e1);
         coord_type lo_x;
         coord_type hi_x;
         coord_type lo_y;
         coord_type hi_y;
         lo_x = (e0.x < e1.x) ? e0.x : e1.x;
         hi_x = (e0.x > e1.x) ? e0.x : e1.x;
         lo_y = (e0.y < e1.y) ? e0.y : e1.y;
         hi_y = (e0.y > e1.y) ? e0.y : e1.y;
         return (m.x >= lo_x) && (m.x <= hi_x) && (m.y >= lo_y) && (m.y <= hi_y);
      endfunction

      function logic [VERDICT_BITS-1:0] verdict_of(seg_pair_type s);
         ori_type  t1;
         ori_type  t2;
         ori_type  t3;
         ori_type  t4;
         diff_type dxa;
         diff_type dya;
         diff_type dxb;
         diff_type dyb;
         t1 = turn_of(s.a0, s.a1, s.b0);
         t2 = turn_of(s.a0, s.a1, s.b1);
         t3 = turn_of(s.b0, s.b1, s.a0);
         t4 = turn_of(s.b0, s.b1, s.a1);
         // Proper crossing, then a collinear end point touching the other segment.
         if (t1 != t2 && t3 != t4) return VERDICT_CROSS;
         if (t1 == ORI_LINE && within_box(s.a0, s.b0, s.a1)) return VERDICT_CROSS;
         if (t2 == ORI_LINE && within_box(s.a0, s.b1, s.a1)) return VERDICT_CROSS;
         if (t3 == ORI_LINE && within_box(s.b0, s.a0, s.b1)) return VERDICT_CROSS;
         if (t4 == ORI_LINE && within_box(s.b0, s.a1, s.b1)) return VERDICT_CROSS;
         if (t1 == ORI_LINE && t2 == ORI_LINE && t3 == ORI_LINE && t4 == ORI_LINE)
            return VERDICT_PARALLEL;
         // No contact: a point-like segment is non-parallel, else compare slopes.
         dxa = diff_type'(s.a1.x) - diff_type'(s.a0.x);
         dya = diff_type'(s.a1.y) - diff_type'(s.a0.y);
         dxb = diff_type'(s.b1.x) - diff_type'(s.b0.x);
         dyb = diff_type'(s.b1.y) - diff_type'(s.b0.y);
         if ((dxa == 0 && dya == 0) || (dxb == 0 && dyb == 0)) return VERDICT_SKEW;
         if (prod_type'(dya) * prod_type'(dxb) == prod_type'(dyb) * prod_type'(dxa))
            return VERDICT_PARALLEL;
         return VERDICT_SKEW;
      endfunction

      function void note_pair(seg_pair_type s);
         pending_verdicts.push_back(RSP_DATA_BITS'(verdict_of(s)));
      endfunction

      // The whole byte is compared, so the zero fill above the verdict is checked too.
      function void check_verdict(logic [RSP_DATA_BITS-1:0] got);
         logic [RSP_DATA_BITS-1:0] want;
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: verdict 0x%0h arrived with none expected", $time, got);
            return;
         end
         want = pending_verdicts.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: verdict mismatch, expected 0x%0h, got 0x%0h",
                        $time, want, got);
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;

   verdict_scoreboard scoreboard = new();
   bit                no_idle;

   segment_intersection_test u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then long, none in busy stretches.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int srand(int m);
      return int'($urandom_range(0, 2 * m)) - m;
   endfunction

   function automatic point_type pt(int x, int y);
      point_type p;
      p.x = coord_type'(x);
      p.y = coord_type'(y);
      return p;
   endfunction

   function automatic seg_pair_type make_pair(int x0, int y0, int x1, int y1,
                                              int x2, int y2, int x3, int y3);
      seg_pair_type s;
      s.a0 = pt(x0, y0);
      s.a1 = pt(x1, y1);
      s.b0 = pt(x2, y2);
      s.b1 = pt(x3, y3);
      return s;
   endfunction

   // Random pair of one flavor: raw coordinates or a shaped geometric relation.
   function automatic seg_pair_type random_pair(int flavor);
      seg_pair_type s;
      int bx;
      int by;
      int dx;
      int dy;
      int k;
      int t;
      bx = srand(16000);
      by = srand(16000);
      dx = srand(60);
      dy = srand(60);
      case (flavor)
         0, 1, 2: begin
            s.a0 = pt($urandom, $urandom);
            s.a1 = pt($urandom, $urandom);
            s.b0 = pt($urandom, $urandom);
            s.b1 = pt($urandom, $urandom);
         end
         3, 9: begin
            s = make_pair(srand(6), srand(6), srand(6), srand(6),
                          srand(6), srand(6), srand(6), srand(6));
         end
         4: begin
            // Same direction; B either offset or on the line of A.
            k = srand(5);
            if ($urandom_range(0, 2) == 0) begin
               t = srand(8);
               s = make_pair(bx, by, bx + k * dx, by + k * dy, bx + t * dx, by + t * dy,
                             bx + (t + srand(5)) * dx, by + (t + srand(5)) * dy);
               s.b1 = pt(bx + (t + k) * dx, by + (t + k) * dy);
            end else begin
               t = srand(5);
               s.a0 = pt(bx, by);
               s.a1 = pt(bx + k * dx, by + k * dy);
               s.b0 = pt(bx + srand(200), by + srand(200));
               s.b1 = pt(s.b0.x + t * dx, s.b0.y + t * dy);
            end
         end
         5: begin
            // All four points on one line.
            s = make_pair(bx + srand(20) * dx, by, 0, 0, 0, 0, 0, 0);
            t = srand(20);
            s.a0 = pt(bx + t * dx, by + t * dy);
            t = srand(20);
            s.a1 = pt(bx + t * dx, by + t * dy);
            t = srand(20);
            s.b0 = pt(bx + t * dx, by + t * dy);
            t = srand(20);
            s.b1 = pt(bx + t * dx, by + t * dy);
         end
         6: begin
            // An end point of B on segment A, sometimes swapped to the far end of B.
            k = $urandom_range(1, 8);
            t = $urandom_range(0, k);
            s.a0 = pt(bx, by);
            s.a1 = pt(bx + k * dx, by + k * dy);
            s.b0 = pt(bx + t * dx, by + t * dy);
            s.b1 = pt(bx + srand(300), by + srand(300));
            if ($urandom_range(0, 1) == 1) begin
               s.b0 = s.b1;
               s.b1 = pt(bx + t * dx, by + t * dy);
            end
         end
         7: begin
            // One or both segments of zero length.
            s = make_pair(srand(6), srand(6), 0, 0, srand(6), srand(6), srand(6), srand(6));
            s.a1 = s.a0;
            if ($urandom_range(0, 1) == 1) s.b1 = s.b0;
         end
         default: begin
            // Vertical A, B vertical or not.
            k = srand(20);
            s = make_pair(k, srand(40), k, srand(40), srand(20), srand(40), 0, srand(40));
            s.b1.x = ($urandom_range(0, 1) == 1) ? s.b0.x : coord_type'(srand(20));
         end
      endcase
      return s;
   endfunction

   // Offers one pair and returns once the request transfer has taken place.
   task automatic send_pair(seg_pair_type s);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {s.b1.y, s.b1.x, s.b0.y, s.b0.x, s.a1.y, s.a1.x, s.a0.y, s.a0.x};
      do @(posedge clock); while (!req_tready);
      scoreboard.note_pair(s);
   endtask

   task automatic send_coords(int x0, int y0, int x1, int y1,
                              int x2, int y2, int x3, int y3);
      send_pair(make_pair(x0, y0, x1, y1, x2, y2, x3, y3));
   endtask

   // Result side: random stalls, with stretches of steady readiness.
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = idle_len();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // Every result transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) scoreboard.check_verdict(rsp_tdata);
   end

   // Main sequence: reset, directed pairs, random pairs, drain.
   initial begin
      no_idle    = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Coordinate extremes and bit patterns.
      send_coords(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
      send_coords(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
      send_coords(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
      send_coords(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767);
      send_coords(32767, -32768, -32768, 32767, 21845, -21846, -21846, 21845);
      send_coords(21845, 21845, -21846, -21846, -21846, 21845, 21845, -21846);
      // Both vertical, then one vertical and one sloped.
      send_coords(-32768, -32768, -32768, 32767, 32767, -32768, 32767, 32767);
      send_coords(0, 0, 0, 10, 5, 0, 6, 20);
      // Crossing, touching at an end point, and a T junction.
      send_coords(0, 0, 10, 10, 0, 10, 10, 0);
      send_coords(0, 0, 10, 0, 10, 0, 20, 5);
      send_coords(0, 0, 10, 0, 5, 0, 5, 8);
      // Collinear overlapping and disjoint, parallel offset and reversed, then non-parallel apart.
      send_coords(0, 0, 10, 0, 5, 0, 15, 0);
      send_coords(0, 0, 4, 4, 6, 6, 9, 9);
      send_coords(0, 0, 4, 2, 0, 3, 8, 7);
      send_coords(0, 0, 10, 5, 10, 7, 0, 2);
      send_coords(0, 0, 4, 0, 6, 1, 9, 9);
      // Zero-length segments: off the line, on the line outside, both points, on the segment, B off A.
      send_coords(3, 3, 3, 3, 0, 0, 10, 1);
      send_coords(20, 0, 20, 0, 0, 0, 10, 0);
      send_coords(1, 2, 1, 2, 5, 7, 5, 7);
      send_coords(5, 0, 5, 0, 0, 0, 10, 0);
      send_coords(0, 0, 10, 0, 7, 7, 7, 7);

      // Random pairs; every third block runs with no idling on either side.
      for (int i = 0; i < 450; i++) begin
         no_idle = ((i / 50) % 3 == 2);
         send_pair(random_pair($urandom_range(0, 10)));
      end
      no_idle = 1'b0;
      req_tvalid <= 1'b0;

      // Drain, then keep watching for any stray result.
      while (scoreboard.pending_verdicts.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (scoreboard.mismatches == 0 && scoreboard.pending_verdicts.size() == 0) begin
         $display("segment_intersection_test regression: pass");
      end else begin
         $display("segment_intersection_test regression: fail");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("segment_intersection_test regression: fail");
      $finish;
   end

endmodule
